// File: rtl/keyed_id_range_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed identifier range allocator
// Shared property templates; synchronous reset disables every check.
// ----------------------------------------------------------------------------
`ifndef KEYED_ID_RANGE_ALLOCATOR_ASSERT_SVH
`define KEYED_ID_RANGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define KIRA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("kira assertion failed");

// next-cycle implication
`define KIRA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("kira assertion failed");

`endif

// File: rtl/kira_pkg.sv
// ----------------------------------------------------------------------------
// kira_pkg
// Shared constants, codes and types of the keyed identifier range allocator.
// ----------------------------------------------------------------------------
package kira_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int ID_W              = 64;

  // request actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DROP   = 2'd1;
  localparam logic [1:0] ACT_ALLOC  = 2'd2;
  localparam logic [1:0] ACT_UPDATE = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_MISSING  = 3'd2;
  localparam logic [2:0] ST_BADCOMBO = 3'd3;
  localparam logic [2:0] ST_ROLLBACK = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // table write enables
  typedef struct packed {
    logic valid_we;
    logic valid_bit;
    logic key_we;
    logic cnt_we;
  } kira_wr_t;

  function automatic int kira_idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// File: rtl/kira_table.sv
// ----------------------------------------------------------------------------
// kira_table
// Valid, key and counter storage; one write port, registered read data.
// ----------------------------------------------------------------------------
module kira_table
  import kira_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IDX_W = kira_idx_w(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  kira_wr_t         wr,
  input  logic [IDX_W-1:0] waddr,
  input  logic [ID_W-1:0]  key_wdata,
  input  logic [ID_W-1:0]  cnt_wdata,
  input  logic [IDX_W-1:0] scan_addr,
  input  logic [IDX_W-1:0] cnt_addr,
  output logic             valid_q,
  output logic [ID_W-1:0]  key_q,
  output logic [ID_W-1:0]  cnt_q
);

  logic            valid_mem [TABLE_ENTRIES];
  logic [ID_W-1:0] key_mem   [TABLE_ENTRIES];
  logic [ID_W-1:0] cnt_mem   [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.valid_we) begin
      valid_mem[waddr] <= wr.valid_bit;
    end
    if (wr.key_we) begin
      key_mem[waddr] <= key_wdata;
    end
    if (wr.cnt_we) begin
      cnt_mem[waddr] <= cnt_wdata;
    end
    valid_q <= valid_mem[scan_addr];
    key_q   <= key_mem[scan_addr];
    cnt_q   <= cnt_mem[cnt_addr];
  end

endmodule

// File: rtl/keyed_id_range_allocator.sv
// ----------------------------------------------------------------------------
// keyed_id_range_allocator
// Table of 64-bit keys with next-free identifier counters: add, drop,
// allocate range, update counter.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// request   | start, busy          | in_action, in_key, in_start_value, ...
// result    | out_valid (strobe)   | out_status, out_first_id, out_end_id
//
// The busy period of a request is set by the serial key scan through the
// table's scan read port, then a counter read (S_LOOKUP) and an execute/
// write-back step (S_EXEC). The result strobe is in the first cycle with busy
// low, so a new request may be accepted in that cycle. After reset the valid
// bits are cleared, one entry a cycle, while busy stays high. Results cannot
// be stalled.
// ----------------------------------------------------------------------------
`include "keyed_id_range_allocator_assert.svh"

module keyed_id_range_allocator
  import kira_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  logic signed [ID_W-1:0] in_key,
  input  logic [ID_W-1:0]        in_start_value,
  input  logic                   in_start_given,
  input  logic [ID_W-1:0]        in_range_count,
  input  logic [ID_W-1:0]        in_step_value,
  input  logic                   in_step_given,
  input  logic                   in_force_back,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [ID_W-1:0]        out_first_id,
  output logic [ID_W-1:0]        out_end_id
);

  localparam int IDX_W = kira_idx_w(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CLEAR_END = CNT_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_LOOKUP, S_EXEC} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] scan_cnt_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  logic [1:0]       act_r;
  logic [ID_W-1:0]  key_r;
  logic [ID_W-1:0]  start_value_r;
  logic [ID_W-1:0]  hint_r;
  logic             start_given_r;
  logic [ID_W-1:0]  range_count_r;
  logic [ID_W-1:0]  step_value_r;
  logic             step_given_r;
  logic             force_back_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [ID_W-1:0]  out_first_r;
  logic [ID_W-1:0]  out_end_r;

  kira_wr_t         wr;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] scan_addr;
  logic [ID_W-1:0]  cnt_wdata;
  logic             valid_q;
  logic [ID_W-1:0]  key_q;
  logic [ID_W-1:0]  cnt_q;
  logic [ID_W-1:0]  add_start;
  logic [ID_W-1:0]  base;
  logic [2:0]       status_nxt;
  logic [ID_W-1:0]  first_nxt;
  logic [ID_W-1:0]  end_nxt;

  kira_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .wr        (wr),
    .waddr     (waddr),
    .key_wdata (key_r),
    .cnt_wdata (cnt_wdata),
    .scan_addr (scan_addr),
    .cnt_addr  (hit_idx_r),
    .valid_q   (valid_q),
    .key_q     (key_q),
    .cnt_q     (cnt_q)
  );

  assign scan_addr = scan_cnt_r[IDX_W-1:0];
  assign add_start = start_given_r ? start_value_r : '0;
  assign base      = (start_given_r && (cnt_q < hint_r)) ? hint_r : cnt_q;

  always_comb begin
    wr         = '0;
    waddr      = hit_idx_r;
    cnt_wdata  = '0;
    status_nxt = ST_OK;
    first_nxt  = '0;
    end_nxt    = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr.valid_we = 1'b1;
        waddr       = scan_addr;
      end
      S_EXEC: begin
        if (act_r == ACT_ADD) begin
          if (hit_r) begin
            status_nxt = ST_EXISTS;
          end else if (!free_r) begin
            status_nxt = ST_FULL;
          end else begin
            wr.valid_we  = 1'b1;
            wr.valid_bit = 1'b1;
            wr.key_we    = 1'b1;
            wr.cnt_we    = 1'b1;
            waddr        = free_idx_r;
            cnt_wdata    = add_start;
            first_nxt    = add_start;
          end
        end else if (!hit_r) begin
          status_nxt = ST_MISSING;
        end else begin
          unique case (act_r)
            ACT_DROP: begin
              wr.valid_we = 1'b1;
            end
            ACT_ALLOC: begin
              wr.cnt_we = 1'b1;
              cnt_wdata = base + range_count_r;
              first_nxt = base;
              end_nxt   = cnt_wdata;
            end
            ACT_UPDATE: begin
              if (start_given_r == step_given_r) begin
                status_nxt = ST_BADCOMBO;
              end else if (start_given_r && (cnt_q > hint_r) && !force_back_r) begin
                status_nxt = ST_ROLLBACK;
              end else begin
                wr.cnt_we = 1'b1;
                cnt_wdata = start_given_r ? hint_r : (cnt_q + step_value_r);
                first_nxt = cnt_wdata;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          if (scan_cnt_r == CLEAR_END) begin
            scan_cnt_r <= '0;
            state_r    <= S_IDLE;
          end else begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            act_r         <= in_action;
            key_r         <= in_key;
            start_value_r <= in_start_value;
            hint_r        <= in_start_value + ID_W'(1);
            start_given_r <= in_start_given;
            range_count_r <= in_range_count;
            step_value_r  <= in_step_value;
            step_given_r  <= in_step_given;
            force_back_r  <= in_force_back;
            hit_r         <= 1'b0;
            free_r        <= 1'b0;
            scan_cnt_r    <= '0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read data arrives in the cycle after its address is issued
          if (cmp_vld_r) begin
            if (valid_q && (key_q == key_r) && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= cmp_idx_r;
            end
            if (!valid_q && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= cmp_idx_r;
            end
          end
          if (scan_cnt_r == SCAN_END) begin
            state_r <= S_LOOKUP;
          end else begin
            cmp_vld_r  <= 1'b1;
            cmp_idx_r  <= scan_addr;
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end
        end
        S_LOOKUP: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_valid_r  <= 1'b1;
          out_status_r <= status_nxt;
          out_first_r  <= first_nxt;
          out_end_r    <= end_nxt;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_first_id = out_first_r;
  assign out_end_id   = out_end_r;

  `KIRA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `KIRA_ASSERT_IMPL(a_result_idle, clk, rst_n, out_valid, !busy)
  `KIRA_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `KIRA_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_first_id == '0) && (out_end_id == '0))
  `KIRA_ASSERT_IMPL(a_exec_after_lookup, clk, rst_n, state_r == S_EXEC, $past(state_r) == S_LOOKUP)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed identifier range allocator. A queue of
// requests (directed corner cases, then random phases that fill and empty
// the key table) feeds a clocked driver with random gaps; a clocked monitor
// checks every result strobe against a table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import kira_pkg::*;

  localparam int NUM_SLOTS     = DEF_TABLE_ENTRIES;
  localparam int KEY_POOL      = 24;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_LEN     = 150;
  localparam int TAIL_CYCLES   = 2 * NUM_SLOTS + 8;

  typedef struct {
    logic [1:0]      action;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] start_value;
    logic            start_given;
    logic [ID_W-1:0] range_count;
    logic [ID_W-1:0] step_value;
    logic            step_given;
    logic            force_back;
    bit              wait_drain;   // hold off until every result is back
  } id_request_t;

  typedef struct {
    logic [2:0]      status;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] end_id;
  } id_outcome_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             in_action = ACT_ADD;
  logic signed [ID_W-1:0] in_key = '0;
  logic [ID_W-1:0]        in_start_value = '0;
  logic                   in_start_given = 1'b0;
  logic [ID_W-1:0]        in_range_count = '0;
  logic [ID_W-1:0]        in_step_value = '0;
  logic                   in_step_given = 1'b0;
  logic                   in_force_back = 1'b0;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [ID_W-1:0]        out_first_id;
  logic [ID_W-1:0]        out_end_id;

  keyed_id_range_allocator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_start_value(in_start_value),
    .in_start_given(in_start_given),
    .in_range_count(in_range_count),
    .in_step_value (in_step_value),
    .in_step_given (in_step_given),
    .in_force_back (in_force_back),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_first_id  (out_first_id),
    .out_end_id    (out_end_id)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  bit              slot_used [NUM_SLOTS];
  logic [ID_W-1:0] slot_key  [NUM_SLOTS];
  logic [ID_W-1:0] slot_next [NUM_SLOTS];

  function automatic id_outcome_t allocator_outcome(input id_request_t rq);
    id_outcome_t     res;
    int              hit;
    int              free_idx;
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] hint;
    logic [ID_W-1:0] cur;
    res.status   = ST_OK;
    res.first_id = '0;
    res.end_id   = '0;
    hit          = -1;
    free_idx     = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == rq.key && hit < 0) hit = i;
      if (!slot_used[i] && free_idx < 0) free_idx = i;
    end
    hint = rq.start_value + 64'd1;
    if (rq.action == ACT_ADD) begin
      // key lookup wins over the full check
      if (hit >= 0) begin
        res.status = ST_EXISTS;
      end else if (free_idx < 0) begin
        res.status = ST_FULL;
      end else begin
        slot_used[free_idx] = 1'b1;
        slot_key[free_idx]  = rq.key;
        slot_next[free_idx] = rq.start_given ? rq.start_value : '0;
        res.first_id        = slot_next[free_idx];
      end
    end else if (hit < 0) begin
      res.status = ST_MISSING;
    end else if (rq.action == ACT_DROP) begin
      slot_used[hit] = 1'b0;
    end else if (rq.action == ACT_ALLOC) begin
      base = slot_next[hit];
      if (rq.start_given && base < hint) base = hint;
      slot_next[hit] = base + rq.range_count;
      res.first_id   = base;
      res.end_id     = slot_next[hit];
    end else begin
      cur = slot_next[hit];
      if (rq.start_given == rq.step_given) begin
        res.status = ST_BADCOMBO;
      end else if (rq.start_given && cur > hint && !rq.force_back) begin
        res.status = ST_ROLLBACK;
      end else begin
        slot_next[hit] = rq.start_given ? hint : cur + rq.step_value;
        res.first_id   = slot_next[hit];
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [ID_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // biased toward the wrap points and toward small counter-like values
  function automatic logic [ID_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return ID_W'($urandom_range(0, 200));
      3: return '1 - ID_W'($urandom_range(0, 40));
      4: return ID_W'($urandom_range(0, 5000));
      default: return rand_word();
    endcase
  endfunction

  function automatic id_request_t mk_req(input logic [1:0] act, input logic [ID_W-1:0] key,
                                         input logic [ID_W-1:0] sv, input logic sg,
                                         input logic [ID_W-1:0] cnt,
                                         input logic [ID_W-1:0] stp, input logic tg,
                                         input logic frc);
    id_request_t rq;
    rq.action      = act;
    rq.key         = key;
    rq.start_value = sv;
    rq.start_given = sg;
    rq.range_count = cnt;
    rq.step_value  = stp;
    rq.step_given  = tg;
    rq.force_back  = frc;
    rq.wait_drain  = 1'b0;
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  id_request_t request_q[$];
  id_outcome_t pending_outcomes[$];
  id_request_t cur_req;
  bit          req_pending = 1'b0;
  bit          idle_on = 1'b1;
  int          gap_left = 0;
  int          issued_total = 0;
  int          checked_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start       <= 1'b0;
      req_pending = 1'b0;
      gap_left    = 0;
    end else begin
      if (start && !busy) begin
        pending_outcomes.push_back(allocator_outcome(cur_req));
        issued_total++;
        req_pending = 1'b0;
        // alternate between stretches with and without gaps
        if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        gap_left = idle_on ? $urandom_range(0, 14) : 0;
      end
      if (!req_pending) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0 &&
                     (!request_q[0].wait_drain || issued_total == checked_cnt)) begin
          cur_req        = request_q.pop_front();
          in_action      <= cur_req.action;
          in_key         <= cur_req.key;
          in_start_value <= cur_req.start_value;
          in_start_given <= cur_req.start_given;
          in_range_count <= cur_req.range_count;
          in_step_value  <= cur_req.step_value;
          in_step_given  <= cur_req.step_given;
          in_force_back  <= cur_req.force_back;
          req_pending    = 1'b1;
        end
      end
      start <= req_pending;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  int          err_cnt = 0;
  int          status_seen[8];
  id_outcome_t want_res;

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      checked_cnt <= checked_cnt + 1;
      if (pending_outcomes.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual status %0d first %h end %h",
                 $time, out_status, out_first_id, out_end_id);
      end else begin
        want_res = pending_outcomes.pop_front();
        status_seen[want_res.status]++;
        check_field("status", ID_W'(want_res.status), ID_W'(out_status));
        check_field("first_id", want_res.first_id, out_first_id);
        check_field("end_id", want_res.end_id, out_end_id);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request list and end of run
  // --------------------------------------------------------------------------
  initial begin : stim
    logic [ID_W-1:0] key_pool[KEY_POOL];
    logic [ID_W-1:0] kmin;
    logic [ID_W-1:0] kmax;
    logic [ID_W-1:0] all1;
    id_request_t     rq;
    int              roll;
    int              add_w[RANDOM_PHASES];
    int              drop_w[RANDOM_PHASES];

    kmin = {1'b1, {(ID_W-1){1'b0}}};
    kmax = {1'b0, {(ID_W-1){1'b1}}};
    all1 = '1;
    key_pool[0] = kmin;
    key_pool[1] = kmax;
    key_pool[2] = '0;
    key_pool[3] = all1;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = rand_word();
    add_w  = '{25, 55, 10, 30, 45, 15, 30};
    drop_w = '{15,  5, 45, 15, 10, 40, 20};

    // empty table: every lookup misses, key check before field check
    request_q.push_back(mk_req(ACT_ALLOC, kmin, 5, 1, 3, 0, 0, 0));
    request_q.push_back(mk_req(ACT_DROP, kmax, 0, 0, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_UPDATE, kmin, 1, 1, 0, 1, 1, 0));
    // add without start stores zero, then duplicate add
    request_q.push_back(mk_req(ACT_ADD, kmin, 64'hDEAD_BEEF_0BAD_F00D, 0, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ADD, kmin, 7, 1, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ADD, kmax, all1, 1, 0, 0, 0, 0));
    // allocation wrapping past the top, hint that wraps to zero
    request_q.push_back(mk_req(ACT_ALLOC, kmax, 0, 0, 2, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ALLOC, kmax, all1, 1, all1, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ALLOC, kmin, 100, 1, 5, 0, 0, 0));
    // bad field combinations, rollback refused and forced, wrapping step
    request_q.push_back(mk_req(ACT_UPDATE, kmin, 9, 1, 0, 9, 1, 1));
    request_q.push_back(mk_req(ACT_UPDATE, kmin, 9, 0, 0, 9, 0, 1));
    request_q.push_back(mk_req(ACT_UPDATE, kmin, 3, 1, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_UPDATE, kmin, 3, 1, 0, 0, 0, 1));
    request_q.push_back(mk_req(ACT_UPDATE, kmin, 0, 0, 0, all1, 1, 0));
    request_q.push_back(mk_req(ACT_UPDATE, kmin, all1, 1, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_UPDATE, kmax, all1, 1, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_DROP, kmin, 0, 0, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ALLOC, kmin, 0, 0, 1, 0, 0, 0));
    // fill the table, then a new key (full) and a present key (exists)
    for (int i = 2; i <= NUM_SLOTS; i++)
      request_q.push_back(mk_req(ACT_ADD, key_pool[i], rand_value(), i[0], 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ADD, key_pool[NUM_SLOTS + 1], 1, 1, 0, 0, 0, 0));
    request_q.push_back(mk_req(ACT_ADD, kmax, 1, 1, 0, 0, 0, 0));

    // random phases with different add/drop balance so the table
    // keeps swinging between empty and full
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int n = 0; n < PHASE_LEN; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_w[p]) rq.action = ACT_ADD;
        else if (roll < add_w[p] + drop_w[p]) rq.action = ACT_DROP;
        else rq.action = $urandom_range(0, 1) ? ACT_ALLOC : ACT_UPDATE;
        rq.key = ($urandom_range(0, 9) == 0) ? rand_word()
                                             : key_pool[$urandom_range(0, KEY_POOL - 1)];
        rq.start_value = rand_value();
        rq.start_given = 1'($urandom_range(0, 1));
        rq.range_count = ($urandom_range(0, 3) == 0) ? rand_value()
                                                     : ID_W'($urandom_range(0, 50));
        rq.step_value  = ($urandom_range(0, 3) == 0) ? rand_value()
                                                     : ID_W'($urandom_range(0, 50));
        rq.step_given  = 1'($urandom_range(0, 1));
        rq.force_back  = ($urandom_range(0, 2) == 0);
        // mostly well-formed updates
        if (rq.action == ACT_UPDATE && $urandom_range(0, 6) != 0)
          rq.step_given = !rq.start_given;
        rq.wait_drain = (n == 0);
        request_q.push_back(rq);
      end
    end

    do @(negedge clk); while (request_q.size() != 0 || req_pending);
    do @(negedge clk); while (pending_outcomes.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d requests over all four actions, table filled and emptied; statuses:",
             issued_total);
    $display("  ok %0d, exists %0d, missing %0d, bad combo %0d, rollback %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_EXISTS], status_seen[ST_MISSING],
             status_seen[ST_BADCOMBO], status_seen[ST_ROLLBACK], status_seen[ST_FULL]);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
